// ===== design/lti_pkg.sv =====
// Shared types, widths, codes and vector arithmetic for the line/triangle intersection block.
package lti_pkg;

   localparam int COORD_BITS    = 16;
   localparam int FRACTION_BITS = 16;
   localparam int VERT_W        = 3 * COORD_BITS;
   localparam int DIFF_W        = COORD_BITS + 1;
   localparam int CROSS_W       = 2 * DIFF_W;
   localparam int DOT_W         = CROSS_W + DIFF_W + 1;
   localparam int MAG_W         = DOT_W - 1;
   localparam int DMAG_W        = COORD_BITS;
   localparam int SPLIT_W       = (MAG_W + 1) / 2;
   localparam int PROD_W        = MAG_W + DMAG_W;
   localparam int NUM_W         = PROD_W + FRACTION_BITS;
   localparam int HIT_W         = 32;
   localparam int QUO_W         = HIT_W + 1;
   localparam int TOT_W         = QUO_W + 3;
   localparam int CSR_IDX_W     = 2;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_A = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_B = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_C = CSR_IDX_W'(2);

   typedef enum logic [2:0] {
      ST_HIT           = 3'd0,
      ST_DEGENERATE    = 3'd1,
      ST_PARALLEL      = 3'd2,
      ST_OUT_OF_BOUNDS = 3'd3,
      ST_OUTSIDE       = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] start_z;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic signed [COORD_BITS-1:0] end_z;
      logic                         bounded_at_start;
      logic                         bounded_at_end;
      logic                         count_edges;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic signed [HIT_W-1:0] hit_x;
      logic signed [HIT_W-1:0] hit_y;
      logic signed [HIT_W-1:0] hit_z;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } pvec_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] z;
   } dvec_type;

   typedef struct packed {
      logic signed [CROSS_W-1:0] x;
      logic signed [CROSS_W-1:0] y;
      logic signed [CROSS_W-1:0] z;
   } cvec_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] x;
      logic signed [DOT_W-1:0] y;
      logic signed [DOT_W-1:0] z;
   } wvec_type;

   typedef struct packed {
      logic bounded_at_start;
      logic bounded_at_end;
      logic count_edges;
   } flags_type;

   // Classified request handed from the front part to the back part.
   typedef struct packed {
      status_type        status;
      pvec_type          p;
      logic [DMAG_W-1:0] dx_mag;
      logic [DMAG_W-1:0] dy_mag;
      logic [DMAG_W-1:0] dz_mag;
      logic [2:0]        d_neg;
      logic [MAG_W-1:0]  a_mag;
      logic              a_neg;
      logic [MAG_W-1:0]  b_mag;
   } mid_type;

   function automatic pvec_type unpack_vertex(logic [VERT_W-1:0] r);
      pvec_type v;
      v.x = signed'(r[COORD_BITS-1:0]);
      v.y = signed'(r[2*COORD_BITS-1:COORD_BITS]);
      v.z = signed'(r[3*COORD_BITS-1:2*COORD_BITS]);
      return v;
   endfunction

   function automatic dvec_type sub3(pvec_type p, pvec_type q);
      dvec_type r;
      r.x = DIFF_W'(p.x) - DIFF_W'(q.x);
      r.y = DIFF_W'(p.y) - DIFF_W'(q.y);
      r.z = DIFF_W'(p.z) - DIFF_W'(q.z);
      return r;
   endfunction

   function automatic cvec_type cross3(dvec_type p, dvec_type q);
      cvec_type r;
      r.x = CROSS_W'(p.y) * CROSS_W'(q.z) - CROSS_W'(p.z) * CROSS_W'(q.y);
      r.y = CROSS_W'(p.z) * CROSS_W'(q.x) - CROSS_W'(p.x) * CROSS_W'(q.z);
      r.z = CROSS_W'(p.x) * CROSS_W'(q.y) - CROSS_W'(p.y) * CROSS_W'(q.x);
      return r;
   endfunction

   function automatic wvec_type mul3(cvec_type c, dvec_type d);
      wvec_type r;
      r.x = DOT_W'(c.x) * DOT_W'(d.x);
      r.y = DOT_W'(c.y) * DOT_W'(d.y);
      r.z = DOT_W'(c.z) * DOT_W'(d.z);
      return r;
   endfunction

   function automatic logic signed [DOT_W-1:0] sum3(wvec_type w);
      return w.x + w.y + w.z;
   endfunction

endpackage

// ===== design/lti_front.sv =====
// Front part: configuration registers, plane crossing arithmetic and classification.
module lti_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  lti_pkg::req_type              in_data,
   input  logic                          advance,
   input  logic                          csr_write,
   input  logic [lti_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lti_pkg::VERT_W-1:0]    csr_wdata,
   output logic                          out_valid,
   output lti_pkg::mid_type              out_data
);
   import lti_pkg::*;

   logic [VERT_W-1:0] vertex_a_ff, vertex_b_ff, vertex_c_ff;
   pvec_type va, vb, vc;

   logic [6:1] valid_ff;

   req_type   s1_req_ff;

   pvec_type  s2_p_ff, s2_p_in;
   flags_type s2_flags_ff, s2_flags_in;
   dvec_type  s2_u_ff, s2_v_ff, s2_cb_ff, s2_w0_ff, s2_d_ff;
   dvec_type  s2_u_in, s2_v_in, s2_cb_in, s2_w0_in, s2_d_in;

   pvec_type  s3_p_ff;
   flags_type s3_flags_ff;
   dvec_type  s3_d_ff, s3_w0_ff;
   cvec_type  s3_n_ff, s3_wv_ff, s3_uw_ff, s3_wc_ff;

   pvec_type  s4_p_ff;
   flags_type s4_flags_ff;
   dvec_type  s4_d_ff;
   logic      s4_nzero_ff;
   wvec_type  s4_pb_ff, s4_pa_ff, s4_ps_ff, s4_pt_ff, s4_pst_ff;

   pvec_type  s5_p_ff;
   flags_type s5_flags_ff;
   dvec_type  s5_d_ff;
   logic      s5_nzero_ff;
   logic signed [DOT_W-1:0] s5_b_ff, s5_a_ff, s5_sn_ff, s5_tn_ff, s5_stn_ff;

   pvec_type  s6_p_ff;
   flags_type s6_flags_ff;
   dvec_type  s6_d_ff;
   logic      s6_nzero_ff, s6_bzero_ff;
   logic signed [DOT_W-1:0] s6_b_ff, s6_a_ff, s6_sn_ff, s6_tn_ff, s6_stn_ff;
   logic signed [DOT_W-1:0] s6_b_in, s6_a_in, s6_sn_in, s6_tn_in, s6_stn_in;

   logic    out_valid_ff;
   mid_type out_data_ff, out_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff <= '0;
         vertex_b_ff <= '0;
         vertex_c_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_VERTEX_A: vertex_a_ff <= csr_wdata;
            REG_VERTEX_B: vertex_b_ff <= csr_wdata;
            REG_VERTEX_C: vertex_c_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign va = unpack_vertex(vertex_a_ff);
   assign vb = unpack_vertex(vertex_b_ff);
   assign vc = unpack_vertex(vertex_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[5:1], in_valid};
         out_valid_ff <= valid_ff[6];
      end
   end

   always_comb begin
      pvec_type q;
      s2_p_in.x = s1_req_ff.start_x;
      s2_p_in.y = s1_req_ff.start_y;
      s2_p_in.z = s1_req_ff.start_z;
      q.x       = s1_req_ff.end_x;
      q.y       = s1_req_ff.end_y;
      q.z       = s1_req_ff.end_z;
      s2_flags_in.bounded_at_start = s1_req_ff.bounded_at_start;
      s2_flags_in.bounded_at_end   = s1_req_ff.bounded_at_end;
      s2_flags_in.count_edges      = s1_req_ff.count_edges;
      s2_u_in  = sub3(vb, va);
      s2_v_in  = sub3(vc, va);
      s2_cb_in = sub3(vc, vb);
      s2_w0_in = sub3(s2_p_in, va);
      s2_d_in  = sub3(q, s2_p_in);
   end

   always_comb begin
      if (s5_b_ff < 0) begin
         s6_b_in   = -s5_b_ff;
         s6_a_in   = -s5_a_ff;
         s6_sn_in  = -s5_sn_ff;
         s6_tn_in  = -s5_tn_ff;
         s6_stn_in = -s5_stn_ff;
      end else begin
         s6_b_in   = s5_b_ff;
         s6_a_in   = s5_a_ff;
         s6_sn_in  = s5_sn_ff;
         s6_tn_in  = s5_tn_ff;
         s6_stn_in = s5_stn_ff;
      end
   end

   always_comb begin
      logic outside;
      logic signed [DOT_W-1:0] a_abs;
      if (s6_flags_ff.count_edges) begin
         outside = (s6_sn_ff < 0) || (s6_sn_ff > s6_b_ff) || (s6_tn_ff < 0) ||
                   (s6_stn_ff > s6_b_ff);
      end else begin
         outside = (s6_sn_ff <= 0) || (s6_sn_ff >= s6_b_ff) || (s6_tn_ff <= 0) ||
                   (s6_stn_ff >= s6_b_ff);
      end
      if (s6_nzero_ff) begin
         out_data_in.status = ST_DEGENERATE;
      end else if (s6_bzero_ff) begin
         out_data_in.status = ST_PARALLEL;
      end else if ((s6_flags_ff.bounded_at_start && s6_a_ff < 0) ||
                   (s6_flags_ff.bounded_at_end && s6_a_ff > s6_b_ff)) begin
         out_data_in.status = ST_OUT_OF_BOUNDS;
      end else if (outside) begin
         out_data_in.status = ST_OUTSIDE;
      end else begin
         out_data_in.status = ST_HIT;
      end
      a_abs               = (s6_a_ff < 0) ? -s6_a_ff : s6_a_ff;
      out_data_in.p       = s6_p_ff;
      out_data_in.a_mag   = a_abs[MAG_W-1:0];
      out_data_in.a_neg   = s6_a_ff < 0;
      out_data_in.b_mag   = s6_b_ff[MAG_W-1:0];
      out_data_in.d_neg   = {s6_d_ff.z < 0, s6_d_ff.y < 0, s6_d_ff.x < 0};
      out_data_in.dx_mag  = DMAG_W'((s6_d_ff.x < 0) ? -s6_d_ff.x : s6_d_ff.x);
      out_data_in.dy_mag  = DMAG_W'((s6_d_ff.y < 0) ? -s6_d_ff.y : s6_d_ff.y);
      out_data_in.dz_mag  = DMAG_W'((s6_d_ff.z < 0) ? -s6_d_ff.z : s6_d_ff.z);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff   <= in_data;

         s2_p_ff     <= s2_p_in;
         s2_flags_ff <= s2_flags_in;
         s2_u_ff     <= s2_u_in;
         s2_v_ff     <= s2_v_in;
         s2_cb_ff    <= s2_cb_in;
         s2_w0_ff    <= s2_w0_in;
         s2_d_ff     <= s2_d_in;

         s3_p_ff     <= s2_p_ff;
         s3_flags_ff <= s2_flags_ff;
         s3_d_ff     <= s2_d_ff;
         s3_w0_ff    <= s2_w0_ff;
         s3_n_ff     <= cross3(s2_u_ff, s2_v_ff);
         s3_wv_ff    <= cross3(s2_w0_ff, s2_v_ff);
         s3_uw_ff    <= cross3(s2_u_ff, s2_w0_ff);
         s3_wc_ff    <= cross3(s2_w0_ff, s2_cb_ff);

         s4_p_ff     <= s3_p_ff;
         s4_flags_ff <= s3_flags_ff;
         s4_d_ff     <= s3_d_ff;
         s4_nzero_ff <= (s3_n_ff == '0);
         s4_pb_ff    <= mul3(s3_n_ff, s3_d_ff);
         s4_pa_ff    <= mul3(s3_n_ff, s3_w0_ff);
         s4_ps_ff    <= mul3(s3_wv_ff, s3_d_ff);
         s4_pt_ff    <= mul3(s3_uw_ff, s3_d_ff);
         s4_pst_ff   <= mul3(s3_wc_ff, s3_d_ff);

         s5_p_ff     <= s4_p_ff;
         s5_flags_ff <= s4_flags_ff;
         s5_d_ff     <= s4_d_ff;
         s5_nzero_ff <= s4_nzero_ff;
         s5_b_ff     <= sum3(s4_pb_ff);
         s5_a_ff     <= -sum3(s4_pa_ff);
         s5_sn_ff    <= sum3(s4_ps_ff);
         s5_tn_ff    <= sum3(s4_pt_ff);
         s5_stn_ff   <= sum3(s4_pst_ff);

         s6_p_ff     <= s5_p_ff;
         s6_flags_ff <= s5_flags_ff;
         s6_d_ff     <= s5_d_ff;
         s6_nzero_ff <= s5_nzero_ff;
         s6_bzero_ff <= (s5_b_ff == '0);
         s6_b_ff     <= s6_b_in;
         s6_a_ff     <= s6_a_in;
         s6_sn_ff    <= s6_sn_in;
         s6_tn_ff    <= s6_tn_in;
         s6_stn_ff   <= s6_stn_in;

         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== design/lti_queue.sv =====
// Short request queue between the front and back parts.
module lti_queue #(
   parameter int DEPTH = lti_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lti_pkg::mid_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output lti_pkg::mid_type pop_data
);
   import lti_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mid_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

endmodule

// ===== design/lti_back.sv =====
// Back part: hit point products, pipelined restoring division, rounding and the result register.
module lti_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  lti_pkg::mid_type q_data,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output lti_pkg::rsp_type rsp_data
);
   import lti_pkg::*;

   typedef struct packed {
      status_type       status;
      logic [2:0]       neg;
      pvec_type         p;
      logic [MAG_W-1:0] b_mag;
   } bctl_type;

   localparam int LO_W = SPLIT_W + DMAG_W;
   localparam int HI_W = MAG_W - SPLIT_W + DMAG_W;
   localparam logic signed [TOT_W-1:0] HIT_MAX =
      {{(TOT_W - HIT_W + 1){1'b0}}, {(HIT_W - 1){1'b1}}};
   localparam logic signed [TOT_W-1:0] HIT_MIN = ~HIT_MAX;

   logic advance;

   logic              b1_valid_ff;
   bctl_type          b1_ctl_ff, b1_ctl_in;
   logic [LO_W-1:0]   b1_lo_ff [3];
   logic [HI_W-1:0]   b1_hi_ff [3];
   logic [DMAG_W-1:0] d_mag [3];

   logic              b2_valid_ff;
   bctl_type          b2_ctl_ff;
   logic [NUM_W-1:0]  b2_num_ff [3];

   logic              dv_valid_ff [QUO_W+1];
   bctl_type          dv_ctl_ff   [QUO_W+1];
   logic [2:0]        dv_sat_ff   [QUO_W+1];
   logic [NUM_W-1:0]  dv_rem_ff   [QUO_W+1][3];
   logic [QUO_W-1:0]  dv_quo_ff   [QUO_W+1][3];

   logic              e1_valid_ff;
   bctl_type          e1_ctl_ff;
   logic [2:0]        e1_sat_ff;
   logic [QUO_W:0]    e1_qa_ff [3];

   logic              out_valid_ff;
   rsp_type           out_data_ff, out_data_in;

   function automatic logic signed [HIT_W-1:0] finish_coord(
      logic signed [COORD_BITS-1:0] p, logic [QUO_W:0] qa, logic neg, logic sat);
      logic signed [COORD_BITS+FRACTION_BITS-1:0] base;
      logic signed [TOT_W-1:0] off;
      logic signed [TOT_W-1:0] tot;
      base = {p, {FRACTION_BITS{1'b0}}};
      off  = signed'(TOT_W'(qa));
      tot  = neg ? TOT_W'(base) - off : TOT_W'(base) + off;
      if (sat) begin
         tot = neg ? HIT_MIN : HIT_MAX;
      end else if (tot > HIT_MAX) begin
         tot = HIT_MAX;
      end else if (tot < HIT_MIN) begin
         tot = HIT_MIN;
      end
      return tot[HIT_W-1:0];
   endfunction

   assign advance = !out_valid_ff || rsp_pop;
   assign q_pop   = advance && !q_empty;

   assign d_mag[0] = q_data.dx_mag;
   assign d_mag[1] = q_data.dy_mag;
   assign d_mag[2] = q_data.dz_mag;

   always_comb begin
      b1_ctl_in.status = q_data.status;
      b1_ctl_in.neg    = q_data.d_neg ^ {3{q_data.a_neg}};
      b1_ctl_in.p      = q_data.p;
      b1_ctl_in.b_mag  = q_data.b_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff    <= 1'b0;
         b2_valid_ff    <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
         e1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else if (advance) begin
         b1_valid_ff    <= !q_empty;
         b2_valid_ff    <= b1_valid_ff;
         dv_valid_ff[0] <= b2_valid_ff;
         e1_valid_ff    <= dv_valid_ff[QUO_W];
         out_valid_ff   <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_ctl_ff    <= b1_ctl_in;
         b2_ctl_ff    <= b1_ctl_ff;
         dv_ctl_ff[0] <= b2_ctl_ff;
         e1_ctl_ff    <= dv_ctl_ff[QUO_W];
         e1_sat_ff    <= dv_sat_ff[QUO_W];
         for (int j = 0; j < 3; j++) begin
            b1_lo_ff[j]     <= LO_W'(q_data.a_mag[SPLIT_W-1:0]) * LO_W'(d_mag[j]);
            b1_hi_ff[j]     <= HI_W'(q_data.a_mag[MAG_W-1:SPLIT_W]) * HI_W'(d_mag[j]);
            b2_num_ff[j]    <= NUM_W'((PROD_W'(b1_hi_ff[j]) << SPLIT_W) +
                                      PROD_W'(b1_lo_ff[j])) << FRACTION_BITS;
            dv_sat_ff[0][j] <= (NUM_W + 2)'(b2_num_ff[j]) >=
                               ((NUM_W + 2)'(b2_ctl_ff.b_mag) << QUO_W);
            dv_rem_ff[0][j] <= b2_num_ff[j];
            dv_quo_ff[0][j] <= '0;
            e1_qa_ff[j]     <= (QUO_W + 1)'(dv_quo_ff[QUO_W][j]) +
                               (QUO_W + 1)'(dv_ctl_ff[QUO_W].neg[j] &&
                                            (dv_rem_ff[QUO_W][j] != '0));
         end
         out_data_ff <= out_data_in;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int SH = QUO_W - 1 - k;
      logic [NUM_W-1:0] rem_in [3];
      logic [QUO_W-1:0] quo_in [3];

      always_comb begin
         logic [NUM_W+1:0] dvs;
         logic [NUM_W+1:0] rem_x;
         dvs = (NUM_W + 2)'(dv_ctl_ff[k].b_mag) << SH;
         for (int j = 0; j < 3; j++) begin
            rem_x     = (NUM_W + 2)'(dv_rem_ff[k][j]);
            rem_in[j] = dv_rem_ff[k][j];
            quo_in[j] = dv_quo_ff[k][j];
            if (rem_x >= dvs) begin
               rem_in[j]     = NUM_W'(rem_x - dvs);
               quo_in[j][SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_ctl_ff[k+1] <= dv_ctl_ff[k];
            dv_sat_ff[k+1] <= dv_sat_ff[k];
            for (int j = 0; j < 3; j++) begin
               dv_rem_ff[k+1][j] <= rem_in[j];
               dv_quo_ff[k+1][j] <= quo_in[j];
            end
         end
      end
   end

   always_comb begin
      out_data_in.status = e1_ctl_ff.status;
      out_data_in.hit_x  = '0;
      out_data_in.hit_y  = '0;
      out_data_in.hit_z  = '0;
      if (e1_ctl_ff.status == ST_HIT) begin
         out_data_in.hit_x = finish_coord(e1_ctl_ff.p.x, e1_qa_ff[0], e1_ctl_ff.neg[0],
                                          e1_sat_ff[0]);
         out_data_in.hit_y = finish_coord(e1_ctl_ff.p.y, e1_qa_ff[1], e1_ctl_ff.neg[1],
                                          e1_sat_ff[1]);
         out_data_in.hit_z = finish_coord(e1_ctl_ff.p.z, e1_qa_ff[2], e1_ctl_ff.neg[2],
                                          e1_sat_ff[2]);
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== design/line_triangle_intersection.sv =====
// Top level of the line/triangle intersection block.
//
//   port group   direction   handshake            payload
//   req_         in          req_push / req_full  req_data (lti_pkg::req_type)
//   rsp_         out         rsp_pop / rsp_empty  rsp_data (lti_pkg::rsp_type)
//   csr_         in          csr_write            csr_index, csr_wdata
//
// One request is accepted every cycle while req_full is low; a result passes through
// 7 front stages, the queue, 2 multiply stages, 34 division stages and 2 rounding stages.
// The division pipeline, one quotient bit per stage, sets the latency.
// Reset clears only control state and the vertex registers; there is no clearing pass.
// A stalled result stalls only the back part; the front keeps accepting until the
// four-entry queue between the two parts fills, then req_full rises.
module line_triangle_intersection #(
   parameter int QUEUE_DEPTH = lti_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  lti_pkg::req_type              req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output lti_pkg::rsp_type              rsp_data,
   input  logic                          csr_write,
   input  logic [lti_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lti_pkg::VERT_W-1:0]    csr_wdata
);
   import lti_pkg::*;

   logic    q_full, q_empty, q_pop, front_valid;
   mid_type front_data, q_data;

   assign req_full = q_full;

   lti_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_push && !q_full),
      .in_data   (req_data),
      .advance   (!q_full),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   lti_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid && !q_full),
      .push_data (front_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   lti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/lti_checker.sv =====
// Port-level assertions for the line/triangle intersection block and their binding.
module lti_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input lti_pkg::rsp_type rsp_data
);
   import lti_pkg::*;

   a_empty_after_reset: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("Result visible right after reset.");

   a_ready_after_reset: assert property (@(posedge clock) $past(reset) |-> !req_full)
      else $error("Request port full right after reset.");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_HIT) |->
      (rsp_data.hit_x == '0 && rsp_data.hit_y == '0 && rsp_data.hit_z == '0))
      else $error("Result without a hit carries a nonzero point.");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("Waiting result changed or vanished.");

endmodule

bind line_triangle_intersection lti_checker u_checker (.*);

// ===== test/line_triangle_intersection_tb.sv =====
// Self-checking testbench for the line/triangle intersection block.
`timescale 1ns / 100ps

module line_triangle_intersection_tb;
   import lti_pkg::*;

   typedef longint lvec_type [3];

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   req_type              req_data = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_VERTEX_A;
   logic [VERT_W-1:0]    csr_wdata = '0;

   logic [VERT_W-1:0] tri_a = '0, tri_b = '0, tri_c = '0;
   rsp_type           pending_hits [$];
   int                errors = 0;
   int                send_idle_pct = 0;
   int                pop_stall_pct = 0;
   int                hold_request = 0;
   int                hold_count = 0;
   int                quiet_cycles = 0;

   line_triangle_intersection u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic lvec_type vertex_of(logic [VERT_W-1:0] r);
      lvec_type v;
      v[0] = longint'(signed'(r[15:0]));
      v[1] = longint'(signed'(r[31:16]));
      v[2] = longint'(signed'(r[47:32]));
      return v;
   endfunction

   function automatic lvec_type vdiff(lvec_type p, lvec_type q);
      lvec_type r;
      for (int i = 0; i < 3; i++) r[i] = p[i] - q[i];
      return r;
   endfunction

   function automatic lvec_type vcross(lvec_type p, lvec_type q);
      lvec_type r;
      r[0] = p[1] * q[2] - p[2] * q[1];
      r[1] = p[2] * q[0] - p[0] * q[2];
      r[2] = p[0] * q[1] - p[1] * q[0];
      return r;
   endfunction

   function automatic longint vdot(lvec_type p, lvec_type q);
      return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
   endfunction

   // Hit coordinate p + dk*an/bn in Q15.16, floored and saturated; bn is positive.
   function automatic logic signed [HIT_W-1:0] fixed_coord(longint p, longint dk,
                                                           longint an, longint bn);
      logic signed [127:0] num, quo, tot;
      num = an;
      num = num * dk * 65536;
      quo = num / bn;
      if (num < 0 && quo * bn != num) quo = quo - 1;
      tot = quo;
      tot = tot + p * 65536;
      if (tot > 128'sd2147483647) tot = 128'sd2147483647;
      if (tot < -128'sd2147483648) tot = -128'sd2147483648;
      return tot[HIT_W-1:0];
   endfunction

   function automatic rsp_type predict_intersection(req_type r);
      rsp_type  o;
      lvec_type va, vb, vc, p, q, u, v, n, d, w0;
      longint   an, bn, sn, tn, stn;
      logic     outside;
      o = '0;
      va = vertex_of(tri_a);
      vb = vertex_of(tri_b);
      vc = vertex_of(tri_c);
      p = '{longint'(r.start_x), longint'(r.start_y), longint'(r.start_z)};
      q = '{longint'(r.end_x), longint'(r.end_y), longint'(r.end_z)};
      u = vdiff(vb, va);
      v = vdiff(vc, va);
      n = vcross(u, v);
      d = vdiff(q, p);
      w0 = vdiff(p, va);
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
         o.status = ST_DEGENERATE;
         return o;
      end
      bn = vdot(n, d);
      if (bn == 0) begin
         o.status = ST_PARALLEL;
         return o;
      end
      an = -vdot(n, w0);
      sn = vdot(d, vcross(w0, v));
      tn = vdot(d, vcross(u, w0));
      stn = vdot(d, vcross(w0, vdiff(vc, vb)));
      if (bn < 0) begin
         an = -an; bn = -bn; sn = -sn; tn = -tn; stn = -stn;
      end
      if ((r.bounded_at_start && an < 0) || (r.bounded_at_end && an > bn)) begin
         o.status = ST_OUT_OF_BOUNDS;
         return o;
      end
      if (r.count_edges)
         outside = sn < 0 || sn > bn || tn < 0 || stn > bn;
      else
         outside = sn <= 0 || sn >= bn || tn <= 0 || stn >= bn;
      if (outside) begin
         o.status = ST_OUTSIDE;
         return o;
      end
      o.status = ST_HIT;
      o.hit_x = fixed_coord(p[0], d[0], an, bn);
      o.hit_y = fixed_coord(p[1], d[1], an, bn);
      o.hit_z = fixed_coord(p[2], d[2], an, bn);
      return o;
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   // Result side: stalls at random, with an optional long hold-off.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_count = hold_request;
         hold_request = 0;
      end
      if (hold_count > 0) hold_count--;
      rsp_pop <= !reset && hold_count == 0 && $urandom_range(99) >= pop_stall_pct;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_hits.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = pending_hits.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.hit_x !== want.hit_x)
               report_mismatch($sformatf("hit_x %0d, expected %0d",
                                         rsp_data.hit_x, want.hit_x));
            if (rsp_data.hit_y !== want.hit_y)
               report_mismatch($sformatf("hit_y %0d, expected %0d",
                                         rsp_data.hit_y, want.hit_y));
            if (rsp_data.hit_z !== want.hit_z)
               report_mismatch($sformatf("hit_z %0d, expected %0d",
                                         rsp_data.hit_z, want.hit_z));
         end
      end
      if ((rsp_pop && !rsp_empty) || (req_push && !req_full))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_vertex(logic [CSR_IDX_W-1:0] idx, logic [VERT_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_VERTEX_A: tri_a = value;
         REG_VERTEX_B: tri_b = value;
         default:      tri_c = value;
      endcase
   endtask

   task automatic set_triangle(logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                               logic [VERT_W-1:0] c);
      write_vertex(REG_VERTEX_A, a);
      write_vertex(REG_VERTEX_B, b);
      write_vertex(REG_VERTEX_C, c);
      csr_write <= 1'b0;
   endtask

   task automatic send_line(req_type item);
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      pending_hits.push_back(predict_intersection(item));
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type make_line(int sx, int sy, int sz, int ex, int ey, int ez,
                                         bit bs, bit be, bit ie);
      req_type r;
      r.start_x = COORD_BITS'(sx); r.start_y = COORD_BITS'(sy); r.start_z = COORD_BITS'(sz);
      r.end_x = COORD_BITS'(ex); r.end_y = COORD_BITS'(ey); r.end_z = COORD_BITS'(ez);
      r.bounded_at_start = bs; r.bounded_at_end = be; r.count_edges = ie;
      return r;
   endfunction

   function automatic logic [VERT_W-1:0] pack_vertex(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   function automatic int jitter(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   // Mostly lines aimed near the centroid so that many cross the triangle.
   function automatic req_type random_line(bit aimed);
      req_type      r;
      logic [127:0] raw;
      lvec_type     va, vb, vc;
      int           hx, hy, hz, ox, oy, oz;
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      if (aimed) begin
         va = vertex_of(tri_a);
         vb = vertex_of(tri_b);
         vc = vertex_of(tri_c);
         hx = int'((va[0] + vb[0] + vc[0]) / 3) + jitter(300);
         hy = int'((va[1] + vb[1] + vc[1]) / 3) + jitter(300);
         hz = int'((va[2] + vb[2] + vc[2]) / 3) + jitter(300);
         ox = jitter(8000); oy = jitter(8000); oz = jitter(8000);
         r.start_x = COORD_BITS'(hx + ox);
         r.start_y = COORD_BITS'(hy + oy);
         r.start_z = COORD_BITS'(hz + oz);
         r.end_x = COORD_BITS'(hx - ox + jitter(200));
         r.end_y = COORD_BITS'(hy - oy + jitter(200));
         r.end_z = COORD_BITS'(hz - oz + jitter(200));
      end
      return r;
   endfunction

   task automatic test_degenerate();
      send_line(make_line(1, 2, -3, 4, 5, 6, 0, 0, 0));
      send_line(make_line(-32768, -32768, -32768, 32767, 32767, 32767, 1, 1, 1));
      wait_idle();
      set_triangle(pack_vertex(0, 0, 0), pack_vertex(10, 10, 10), pack_vertex(-20, -20, -20));
      send_line(make_line(0, 0, -5, 0, 0, 5, 0, 0, 1));
      wait_idle();
   endtask

   task automatic test_directed();
      set_triangle(pack_vertex(0, 0, 0), pack_vertex(100, 0, 0), pack_vertex(0, 100, 0));
      send_line(make_line(10, 10, -5, 10, 10, 5, 1, 1, 0));
      send_line(make_line(10, 10, -5, 30, 10, 5, 1, 1, 1));
      send_line(make_line(10, 10, 5, 10, 20, 5, 0, 0, 0));
      send_line(make_line(10, 10, 0, 40, 10, 0, 0, 0, 1));
      send_line(make_line(7, 7, 7, 7, 7, 7, 0, 0, 0));
      send_line(make_line(10, 10, 1, 10, 10, 5, 1, 0, 0));
      send_line(make_line(10, 10, 1, 10, 10, 5, 0, 0, 0));
      send_line(make_line(10, 10, -5, 10, 10, -1, 0, 1, 0));
      send_line(make_line(10, 10, 0, 10, 10, 4, 1, 1, 0));
      send_line(make_line(10, 10, -4, 10, 10, 0, 1, 1, 0));
      send_line(make_line(0, 50, -1, 0, 50, 1, 0, 0, 0));
      send_line(make_line(0, 50, -1, 0, 50, 1, 0, 0, 1));
      send_line(make_line(50, 50, -1, 50, 50, 1, 0, 0, 0));
      send_line(make_line(50, 50, -1, 50, 50, 1, 0, 0, 1));
      send_line(make_line(0, 0, -1, 0, 0, 1, 1, 1, 1));
      send_line(make_line(200, 10, -1, 200, 10, 1, 0, 0, 1));
      send_line(make_line(1, 1, -3, 2, 2, 4, 1, 1, 0));
      send_line(make_line(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 1));
      wait_idle();
      set_triangle(pack_vertex(-32768, -32768, 0), pack_vertex(32767, -32768, 0),
                   pack_vertex(-32768, 32767, 0));
      send_line(make_line(-32768, -32768, -32768, -32768, -32768, 32767, 1, 1, 1));
      send_line(make_line(32767, 32767, 32767, -32768, -32768, -32767, 0, 0, 1));
      send_line(make_line(-100, 5, 1, 100, -5, -32768, 0, 0, 0));
      wait_idle();
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct, bit full_range);
      if (full_range)
         set_triangle(VERT_W'({$urandom, $urandom}), VERT_W'({$urandom, $urandom}),
                      VERT_W'({$urandom, $urandom}));
      else
         set_triangle(pack_vertex(jitter(8000), jitter(8000), jitter(8000)),
                      pack_vertex(jitter(8000), jitter(8000), jitter(8000)),
                      pack_vertex(jitter(8000), jitter(8000), jitter(8000)));
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      repeat (count) send_line(random_line(!full_range && $urandom_range(99) < 75));
      wait_idle();
      send_idle_pct = 0;
      pop_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      set_triangle(pack_vertex(-5000, -4000, 100), pack_vertex(6000, -3000, -200),
                   pack_vertex(500, 7000, 300));
      hold_request = 300;
      repeat (80) send_line(random_line($urandom_range(1) != 0));
      wait_idle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_degenerate();
      test_directed();
      test_random(70, 0, 0, 0);
      test_random(70, 62, 0, 0);
      test_random(70, 0, 62, 0);
      test_random(70, 34, 34, 0);
      test_random(40, 34, 34, 1);
      test_backpressure();
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
